// File: hdl/ptlru_pkg.sv
// ----------------------------------------------------------------------------
// ptlru_pkg: shared types and constants of the page table allocator.
// Widths, request, status and state codes, the entry record passed along the cells and the write command.
// ----------------------------------------------------------------------------
package ptlru_pkg;

  localparam int unsigned VIRT_PAGES  = 64;
  localparam int unsigned PHYS_FRAMES = 16;
  localparam int unsigned STAMP_BITS  = 32;
  localparam int unsigned VP_W        = 6;
  localparam int unsigned FR_W        = 4;
  localparam int unsigned CNT_W       = $clog2(VIRT_PAGES + 1);

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_DIRTY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_HELD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_APPLY = 2'd2,
    S_OUT   = 2'd3
  } state_e;

  // Contents of one page table entry as it travels around the ring.
  typedef struct packed {
    logic                  present;
    logic                  dirty;
    logic [FR_W-1:0]       frame;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  // Per-entry write command applied while the ring rotates.
  typedef struct packed {
    logic                  clear;
    logic                  set_dirty;
    logic                  fill;
    logic [FR_W-1:0]       frame;
    logic [STAMP_BITS-1:0] stamp;
  } cmd_t;

endpackage

// File: hdl/ptlru_if.sv
// ----------------------------------------------------------------------------
// ptlru_req_if / ptlru_rsp_if: valid/ready channels of the allocator.
// Requests carry kind and frame; responses carry the full result item.
// ----------------------------------------------------------------------------
interface ptlru_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] frame;
  modport source (output valid, kind, frame, input ready);
  modport sink   (input valid, kind, frame, output ready);
endinterface

interface ptlru_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] virt_page;
  logic [3:0] granted_frame;
  logic       evicted;
  logic [5:0] evicted_page;
  logic       writeback;
  modport source (output valid, status, virt_page, granted_frame, evicted,
                  evicted_page, writeback, input ready);
  modport sink   (input valid, status, virt_page, granted_frame, evicted,
                  evicted_page, writeback, output ready);
endinterface

// File: hdl/ptlru_cell.sv
// ----------------------------------------------------------------------------
// ptlru_cell: one page table entry in the rotating ring.
// On each shift it takes its neighbor's entry, optionally rewritten by a command.
// ----------------------------------------------------------------------------
module ptlru_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             cmd_en_i,
  input  ptlru_pkg::cmd_t  cmd_i,
  input  ptlru_pkg::entry_t prev_i,
  output ptlru_pkg::entry_t ent_o
);
  import ptlru_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = prev_i;
    if (cmd_en_i) begin
      if (cmd_i.clear) begin
        ent_d.present = 1'b0;
        ent_d.dirty   = 1'b0;
      end
      if (cmd_i.set_dirty) ent_d.dirty = 1'b1;
      if (cmd_i.fill) begin
        ent_d.present = 1'b1;
        ent_d.dirty   = 1'b0;
        ent_d.frame   = cmd_i.frame;
        ent_d.stamp   = cmd_i.stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (shift_i) begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;
endmodule

// File: hdl/page_table_lru_allocator.sv
// ----------------------------------------------------------------------------
// page_table_lru_allocator: page table with LRU frame replacement.
// Entries rotate through a ring of cells; a head cell is examined per cycle.
// ----------------------------------------------------------------------------
// Each request makes one full rotation of the entry ring to find the free
// slot, the oldest stamp or the frame holder, one rotation to write the
// change back into the chosen entry, and passes the accept and result
// states. A new request is taken once the previous result has been handed
// off from the output register.
module page_table_lru_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptlru_req_if.sink   req,
  ptlru_rsp_if.source rsp
);
  import ptlru_pkg::*;

  entry_t ring [VIRT_PAGES];
  logic   [VIRT_PAGES-1:0] cmd_en;
  cmd_t   cmd;
  logic   shift;

  state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q;
  logic [VP_W-1:0]       pos_q;
  logic [1:0]            kind_q;
  logic [FR_W-1:0]       frame_q;
  logic [PHYS_FRAMES-1:0] used_q;
  logic [STAMP_BITS-1:0] stamp_cnt_q;
  // Scan results.
  logic                  free_found_q, hold_found_q, vic_found_q;
  logic [VP_W-1:0]       free_idx_q, hold_idx_q, vic_idx_q;
  logic [STAMP_BITS-1:0] best_age_q;
  logic [FR_W-1:0]       vic_frame_q;
  logic                  vic_dirty_q;
  // Decision taken after the scan.
  logic                  do_fill_q, do_clr_q, do_dirty_q;
  logic [VP_W-1:0]       tgt_idx_q, clr_idx_q;
  logic [FR_W-1:0]       nf_q;
  logic [1:0]            st_q;
  logic [VP_W-1:0]       vp_q, evp_q;
  logic [FR_W-1:0]       gf_q;
  logic                  ev_q, wb_q, rvalid_q;

  for (genvar g = 0; g < VIRT_PAGES; g++) begin : g_cell
    ptlru_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .cmd_en_i(cmd_en[g]),
      .cmd_i   (cmd),
      .prev_i  (ring[(g + 1) % VIRT_PAGES]),
      .ent_o   (ring[g])
    );
  end

  // Cell 0 holds entry pos_q; it takes cell 1's entry on each shift.
  entry_t head;
  assign head  = ring[0];
  assign shift = (state_q == S_SCAN) || (state_q == S_APPLY);

  logic [STAMP_BITS-1:0] age;
  logic [FR_W-1:0]       free_fr;
  logic                  any_free;
  assign age = stamp_cnt_q - head.stamp;

  always_comb begin
    any_free = 1'b0;
    free_fr  = '0;
    for (int i = PHYS_FRAMES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        any_free = 1'b1;
        free_fr  = FR_W'(i);
      end
    end
  end

  // The last cell receives the head entry; commands hit it as head leaves.
  always_comb begin
    cmd_en = '0;
    cmd    = '0;
    cmd.frame = nf_q;
    cmd.stamp = stamp_cnt_q;
    if (state_q == S_APPLY) begin
      if (do_fill_q && pos_q == tgt_idx_q) begin
        cmd.fill = 1'b1;
        cmd_en[VIRT_PAGES-1] = 1'b1;
      end
      if (do_clr_q && pos_q == clr_idx_q) begin
        cmd.clear = 1'b1;
        cmd_en[VIRT_PAGES-1] = 1'b1;
      end
      if (do_dirty_q && pos_q == tgt_idx_q) begin
        cmd.set_dirty = 1'b1;
        cmd_en[VIRT_PAGES-1] = 1'b1;
      end
    end
  end

  logic last;
  assign last = (cnt_q == CNT_W'(VIRT_PAGES - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req.valid && !rvalid_q) state_d = S_SCAN;
      S_SCAN:  if (last) state_d = S_APPLY;
      S_APPLY: if (last) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign req.ready         = (state_q == S_IDLE) && !rvalid_q;
  assign rsp.valid         = rvalid_q;
  assign rsp.status        = st_q;
  assign rsp.virt_page     = vp_q;
  assign rsp.granted_frame = gf_q;
  assign rsp.evicted       = ev_q;
  assign rsp.evicted_page  = evp_q;
  assign rsp.writeback     = wb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      used_q      <= '0;
      stamp_cnt_q <= '0;
      rvalid_q    <= 1'b0;
      do_fill_q   <= 1'b0;
      do_clr_q    <= 1'b0;
      do_dirty_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift) begin
        pos_q <= pos_q + 1'b1;
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end
      if (rsp.valid && rsp.ready) rvalid_q <= 1'b0;
      if (state_q == S_SCAN && last) begin
        logic df, dc, dd;
        df = 1'b0;
        dc = 1'b0;
        dd = 1'b0;
        unique case (kind_q)
          KIND_ALLOC: if (free_found_q || !head.present) begin
            df = 1'b1;
            if (!any_free && (vic_found_q || head.present)) dc = 1'b1;
          end
          KIND_FREE:  if (hold_found_q || (head.present && head.frame == frame_q))
            dc = 1'b1;
          KIND_DIRTY: if (hold_found_q || (head.present && head.frame == frame_q))
            dd = 1'b1;
          default: ;
        endcase
        do_fill_q  <= df;
        do_clr_q   <= dc;
        do_dirty_q <= dd;
      end
      if (state_q == S_APPLY && last) begin
        rvalid_q <= 1'b1;
        if (do_fill_q) begin
          used_q[nf_q] <= 1'b1;
          stamp_cnt_q  <= stamp_cnt_q + 1'b1;
        end
        if (do_clr_q && kind_q == KIND_FREE) used_q[frame_q] <= 1'b0;
      end
    end
  end

  // Scan datapath and result assembly.
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      kind_q       <= req.kind;
      frame_q      <= req.frame;
      free_found_q <= 1'b0;
      hold_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
      best_age_q   <= '0;
    end
    if (state_q == S_SCAN) begin
      if (!head.present && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= pos_q;
      end
      if (head.present && head.frame == frame_q && !hold_found_q) begin
        hold_found_q <= 1'b1;
        hold_idx_q   <= pos_q;
      end
      if (head.present && (!vic_found_q || age > best_age_q)) begin
        vic_found_q <= 1'b1;
        vic_idx_q   <= pos_q;
        best_age_q  <= age;
        vic_frame_q <= head.frame;
        vic_dirty_q <= head.dirty;
      end
    end
    if (state_q == S_SCAN && last) begin
      // Fold in the final entry, which the registered trackers have not seen.
      logic ff, hf, vf, vd;
      logic [VP_W-1:0] fi, hi, vi;
      logic [FR_W-1:0] vfr;
      logic [1:0]      st;
      logic [VP_W-1:0] vp, evp;
      logic [FR_W-1:0] gf, nf;
      logic            ev, wb;
      ff = free_found_q; fi = free_idx_q;
      hf = hold_found_q; hi = hold_idx_q;
      vf = vic_found_q;  vi = vic_idx_q; vfr = vic_frame_q; vd = vic_dirty_q;
      if (!head.present && !ff) begin ff = 1'b1; fi = pos_q; end
      if (head.present && head.frame == frame_q && !hf) begin hf = 1'b1; hi = pos_q; end
      if (head.present && (!vf || age > best_age_q)) begin
        vf = 1'b1; vi = pos_q; vfr = head.frame; vd = head.dirty;
      end
      st  = ST_OK;
      vp  = '0;
      gf  = '0;
      ev  = 1'b0;
      evp = '0;
      wb  = 1'b0;
      nf  = '0;
      unique case (kind_q)
        KIND_ALLOC: begin
          if (!ff) st = ST_FULL;
          else begin
            tgt_idx_q <= fi;
            vp        = fi;
            if (any_free) begin
              nf = free_fr; gf = free_fr;
            end else if (vf) begin
              nf = vfr; gf = vfr;
              clr_idx_q <= vi;
              ev = 1'b1; evp = vi; wb = vd;
            end
          end
        end
        KIND_FREE, KIND_DIRTY: begin
          if (!hf) st = ST_NOT_HELD;
          else begin
            vp = hi; tgt_idx_q <= hi; clr_idx_q <= hi;
          end
        end
        default: st = ST_NOT_HELD;
      endcase
      st_q  <= st;
      vp_q  <= vp;
      gf_q  <= gf;
      ev_q  <= ev;
      evp_q <= evp;
      wb_q  <= wb;
      nf_q  <= nf;
    end
  end
endmodule
